// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on the rising edge
// and switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/bmh_pkg.sv
package bmh_pkg;

    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller; each one marks the step the datapath is to do.
    typedef struct packed {
        logic accept;
        logic up_step;
        logic up_cmp;
        logic dn_last;
        logic dn_rdl;
        logic dn_rdr;
        logic dn_cmp;
        logic load_out;
    } t_cmd;

    // Conditions that the datapath reports back to the controller.
    typedef struct packed {
        logic in_op;
        logic full;
        logic empty;
        logic last_one;
        logic pos_zero;
        logic no_left;
        logic up_move;
        logic dn_move;
    } t_sts;

endpackage

// File: rtl/bmh_ctrl.sv
module bmh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  bmh_pkg::t_sts i_sts,
    output bmh_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP      = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_DN_LAST = 3'd3;
    localparam logic [2:0] S_DN_RDL  = 3'd4;
    localparam logic [2:0] S_DN_RDR  = 3'd5;
    localparam logic [2:0] S_DN_CMP  = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    if (i_sts.in_op == bmh_pkg::OP_INSERT) begin
                        n_state = i_sts.full ? S_DONE : S_UP;
                    end else begin
                        n_state = (i_sts.empty || i_sts.last_one) ? S_DONE : S_DN_LAST;
                    end
                end
            end
            S_UP: begin
                o_cmd.up_step = 1'b1;
                n_state = i_sts.pos_zero ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
                o_cmd.up_cmp = 1'b1;
                n_state = i_sts.up_move ? S_UP : S_DONE;
            end
            S_DN_LAST: begin
                o_cmd.dn_last = 1'b1;
                n_state = S_DN_RDL;
            end
            S_DN_RDL: begin
                o_cmd.dn_rdl = 1'b1;
                n_state = i_sts.no_left ? S_DONE : S_DN_RDR;
            end
            S_DN_RDR: begin
                o_cmd.dn_rdr = 1'b1;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.dn_cmp = 1'b1;
                n_state = i_sts.dn_move ? S_DN_RDL : S_DONE;
            end
            S_DONE: begin
                o_cmd.load_out = !r_out_valid || !i_out_stall;
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/bmh_dp.sv
module bmh_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bmh_pkg::t_cmd                          i_cmd,
    output bmh_pkg::t_sts                          o_sts,
    input  logic                                   i_op,
    input  logic signed [bmh_pkg::DATA_W-1:0]      i_value,
    output logic signed [bmh_pkg::DATA_W-1:0]      o_extracted_value,
    output logic signed [bmh_pkg::DATA_W-1:0]      o_top_value,
    output logic        [bmh_pkg::COUNT_W-1:0]     o_element_count,
    output logic        [bmh_pkg::STATUS_W-1:0]    o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    logic signed [bmh_pkg::DATA_W-1:0] r_mem [CAPACITY];
    logic signed [bmh_pkg::DATA_W-1:0] r_rdata;

    logic        [CW-1:0]               r_count;
    logic        [AW-1:0]               r_pos;
    logic signed [bmh_pkg::DATA_W-1:0]  r_val;
    logic signed [bmh_pkg::DATA_W-1:0]  r_root;
    logic signed [bmh_pkg::DATA_W-1:0]  r_left;
    logic signed [bmh_pkg::DATA_W-1:0]  r_extr;
    logic        [bmh_pkg::STATUS_W-1:0] r_stat;

    logic signed [bmh_pkg::DATA_W-1:0]  r_o_extr;
    logic signed [bmh_pkg::DATA_W-1:0]  r_o_top;
    logic        [bmh_pkg::COUNT_W-1:0] r_o_count;
    logic        [bmh_pkg::STATUS_W-1:0] r_o_stat;

    logic                               w_we;
    logic        [AW-1:0]               w_wa;
    logic signed [bmh_pkg::DATA_W-1:0]  w_wd;
    logic                               w_re;
    logic        [AW-1:0]               w_ra;

    logic [AW-1:0] w_parent;
    logic [XW-1:0] w_left_idx;
    logic [XW-1:0] w_right_idx;
    logic [CW-1:0] w_count_dec;
    logic [CW-1:0] w_count_inc;
    logic          w_right_ok;
    logic          w_left_win;
    logic          w_right_win;

    assign w_parent    = (r_pos - AW'(1)) >> 1;
    assign w_left_idx  = {1'b0, r_pos, 1'b1};
    assign w_right_idx = w_left_idx + XW'(1);
    assign w_count_dec = r_count - CW'(1);
    assign w_count_inc = r_count + CW'(1);
    assign w_right_ok  = (w_right_idx < XW'(r_count));
    assign w_left_win  = (r_left > r_val);
    assign w_right_win = w_right_ok && (r_rdata > (w_left_win ? r_left : r_val));

    assign o_sts.in_op    = i_op;
    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.last_one = (r_count == CW'(1));
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.no_left  = (w_left_idx >= XW'(r_count));
    assign o_sts.up_move  = (r_rdata < r_val);
    assign o_sts.dn_move  = w_left_win || w_right_win;

    // Memory port control: the moving value rides in r_val while the hole walks.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_pos;
        w_wd = r_val;
        w_re = 1'b0;
        w_ra = w_parent;
        if (i_cmd.accept) begin
            w_re = (i_op == bmh_pkg::OP_EXTRACT) && !o_sts.empty && !o_sts.last_one;
            w_ra = w_count_dec[AW-1:0];
        end
        if (i_cmd.up_step) begin
            w_we = o_sts.pos_zero;
            w_re = !o_sts.pos_zero;
            w_ra = w_parent;
        end
        if (i_cmd.up_cmp) begin
            w_we = 1'b1;
            w_wd = o_sts.up_move ? r_rdata : r_val;
        end
        if (i_cmd.dn_rdl) begin
            w_we = o_sts.no_left;
            w_re = !o_sts.no_left;
            w_ra = w_left_idx[AW-1:0];
        end
        if (i_cmd.dn_rdr) begin
            w_re = w_right_ok;
            w_ra = w_right_idx[AW-1:0];
        end
        if (i_cmd.dn_cmp) begin
            w_we = 1'b1;
            if (w_right_win) begin
                w_wd = r_rdata;
            end else if (w_left_win) begin
                w_wd = r_left;
            end else begin
                w_wd = r_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept) begin
            if (i_op == bmh_pkg::OP_INSERT) begin
                if (!o_sts.full) begin
                    r_count <= w_count_inc;
                end
            end else if (!o_sts.empty) begin
                r_count <= w_count_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && (w_wa == '0)) begin
            r_root <= w_wd;
        end
        if (i_cmd.accept) begin
            r_val  <= i_value;
            r_pos  <= r_count[AW-1:0];
            if (i_op == bmh_pkg::OP_INSERT) begin
                r_extr <= '0;
                r_stat <= o_sts.full ? bmh_pkg::ST_FULL : bmh_pkg::ST_OK;
            end else if (o_sts.empty) begin
                r_extr <= '0;
                r_stat <= bmh_pkg::ST_EMPTY;
            end else begin
                r_extr <= r_root;
                r_stat <= bmh_pkg::ST_OK;
            end
        end
        if (i_cmd.up_cmp && o_sts.up_move) begin
            r_pos <= w_parent;
        end
        if (i_cmd.dn_last) begin
            r_val <= r_rdata;
            r_pos <= '0;
        end
        if (i_cmd.dn_rdr) begin
            r_left <= r_rdata;
        end
        if (i_cmd.dn_cmp) begin
            if (w_right_win) begin
                r_pos <= w_right_idx[AW-1:0];
            end else if (w_left_win) begin
                r_pos <= w_left_idx[AW-1:0];
            end
        end
        if (i_cmd.load_out) begin
            r_o_extr  <= r_extr;
            r_o_top   <= o_sts.empty ? '0 : r_root;
            r_o_count <= bmh_pkg::COUNT_W'(r_count);
            r_o_stat  <= r_stat;
        end
    end

    assign o_extracted_value = r_o_extr;
    assign o_top_value       = r_o_top;
    assign o_element_count   = r_o_count;
    assign o_status          = r_o_stat;

endmodule

// File: rtl/binary_max_heap_priority_queue_top.sv
// A dropped insert, or an extract from a heap of at most one item, goes straight from
// acceptance to its registered result; any other item first walks the heap.
// Throughput: one item at a time; the input stalls until the item's result is registered.
// A new item is taken the cycle after the previous result is registered, even if it waits.
// Reset (synchronous, active low) empties the heap by clearing the count and idles the output;
// the store itself is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module binary_max_heap_priority_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel: an item is taken when i_in_valid is high and o_in_stall is low.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic signed [bmh_pkg::DATA_W-1:0]   i_value,
    // Result channel: an item is delivered when o_out_valid is high and i_out_stall is low.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [bmh_pkg::DATA_W-1:0]   o_extracted_value,
    output logic signed [bmh_pkg::DATA_W-1:0]   o_top_value,
    output logic        [bmh_pkg::COUNT_W-1:0]  o_element_count,
    output logic        [bmh_pkg::STATUS_W-1:0] o_status
);

    // The controller steps through the sift sequences; the datapath owns the store,
    // the element count, the root copy and the result register.
    bmh_pkg::t_cmd w_cmd;
    bmh_pkg::t_sts w_sts;

    bmh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // An insert moves the hole upward, one parent read and one compare per level.
    // An extract refills the root from the last slot and moves the hole downward,
    // reading the left and then the right child before each compare.
    bmh_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_op              (i_op),
        .i_value           (i_value),
        .o_extracted_value (o_extracted_value),
        .o_top_value       (o_top_value),
        .o_element_count   (o_element_count),
        .o_status          (o_status)
    );

    // An accepted item keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // A failed extract reports an empty heap with zeroed values.
    `ASSERT_SAME(a_empty_result, i_clk, i_rst_n, o_out_valid && (o_status == bmh_pkg::ST_EMPTY), (o_extracted_value == '0) && (o_top_value == '0) && (o_element_count == '0))
    // A dropped insert never reports an extracted value.
    `ASSERT_SAME(a_full_result, i_clk, i_rst_n, o_out_valid && (o_status == bmh_pkg::ST_FULL), o_extracted_value == '0)

endmodule
